>>> rtl/mpq_pkg.sv
package mpq_pkg;

	localparam int PIX_W    = 8;
	localparam int REGION_W = 4;
	localparam int GRAY_W   = 8;
	localparam int CFG_W    = 32;
	localparam int IDX_W    = 8;

	localparam int PROD_X_W    = 12;
	localparam int RECIP_SHIFT = 16;
	localparam int RECIP_W     = 17;
	localparam int PROD_W      = PROD_X_W + RECIP_W;

	localparam logic [PIX_W-1:0]  PIX_MAX  = 8'hFF;
	localparam logic [GRAY_W-1:0] GRAY_MAX = 8'hFF;

	localparam logic [IDX_W-1:0] REG_THRESHOLD_COUNT = 8'd0;
	localparam logic [IDX_W-1:0] REG_THRESHOLDS_LOW  = 8'd1;
	localparam logic [IDX_W-1:0] REG_THRESHOLDS_HIGH = 8'd2;
	localparam logic [IDX_W-1:0] REG_INVERT_GRAY     = 8'd3;

	typedef struct packed {
		logic [REGION_W-1:0] count;
		logic [CFG_W-1:0]    thr_low;
		logic [CFG_W-1:0]    thr_high;
		logic                invert;
	} cfg_t;

	function automatic logic [REGION_W-1:0] clamp_count(input logic [REGION_W-1:0] count,
		input logic [REGION_W-1:0] max_n);
		return (count > max_n) ? max_n : count;
	endfunction

	// ceil(2^16 / (n + 1)); exact floor division for numerators up to 2048
	function automatic logic [RECIP_W-1:0] recip(input logic [REGION_W-1:0] n);
		logic [RECIP_W-1:0] r;
		case (n)
			4'd0: r = 17'd65536;
			4'd1: r = 17'd32768;
			4'd2: r = 17'd21846;
			4'd3: r = 17'd16384;
			4'd4: r = 17'd13108;
			4'd5: r = 17'd10923;
			4'd6: r = 17'd9363;
			4'd7: r = 17'd8192;
			4'd8: r = 17'd7282;
			default: r = 17'd7282;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/mpq_if.sv
interface mpq_pixel_if import mpq_pkg::*;;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel;

	modport source(output valid, output pixel, input ready);
	modport sink(input valid, input pixel, output ready);
endinterface

interface mpq_result_if import mpq_pkg::*;;
	logic                valid;
	logic                ready;
	logic [REGION_W-1:0] region_index;
	logic [GRAY_W-1:0]   gray_level;

	modport source(output valid, output region_index, output gray_level, input ready);
	modport sink(input valid, input region_index, input gray_level, output ready);
endinterface

interface mpq_cfg_if import mpq_pkg::*;;
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] index;
	logic [CFG_W-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

>>> rtl/mpq_classify.sv
module mpq_classify import mpq_pkg::*; #(
	parameter int MAX_THRESHOLDS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [PIX_W-1:0]    pixel,
	input  cfg_t                cfg,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [REGION_W-1:0] region
);

	localparam int NREG = MAX_THRESHOLDS + 1;
	localparam logic [REGION_W-1:0] MAX_N = REGION_W'(MAX_THRESHOLDS);

	logic [REGION_W-1:0] n;
	logic [2*CFG_W-1:0]  thr_all;
	logic [NREG-1:0]     hit;
	logic [REGION_W-1:0] region_c;

	logic                v_s1, v_s2;
	logic [NREG-1:0]     hit_s1;
	logic [REGION_W-1:0] region_s2;
	logic                rdy1, rdy2;

	assign n       = clamp_count(cfg.count, MAX_N);
	assign thr_all = {cfg.thr_high, cfg.thr_low};

	// interval i is [b(i), b(i+1)], b(0) = 0, b(n+1) = 255
	for (genvar i = 0; i < NREG; i++) begin : g_cmp
		logic [PIX_W-1:0] lo, hi;
		if (i == 0) begin : g_lo0
			assign lo = '0;
		end else begin : g_lo
			assign lo = thr_all[(i-1)*PIX_W +: PIX_W];
		end
		if (i < MAX_THRESHOLDS) begin : g_hi
			assign hi = (REGION_W'(i) < n) ? thr_all[i*PIX_W +: PIX_W] : PIX_MAX;
		end else begin : g_hi_top
			assign hi = PIX_MAX;
		end
		assign hit[i] = (REGION_W'(i) <= n) && (pixel >= lo) && (pixel <= hi);
	end

	assign rdy2     = !v_s2 || out_ready;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_comb begin
		region_c = n;
		for (int i = NREG - 1; i >= 0; i--) begin
			if (hit_s1[i]) region_c = REGION_W'(i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) hit_s1 <= hit;
		if (rdy2 && v_s1) region_s2 <= region_c;
	end

	assign out_valid = v_s2;
	assign region    = region_s2;

endmodule

>>> rtl/multilevel_pixel_quantizer.sv
// channel  modport  payload                        transaction when
// pix      sink     pixel[7:0]                     pix.valid & pix.ready
// res      source   region_index[3:0], gray[7:0]   res.valid & res.ready
// cfg      sink     index[7:0], data[31:0]         cfg.valid & cfg.ready (ready tied high)
//
// One pixel per cycle unless the output stalls; the stages are compare, priority encode,
// reciprocal multiply, scale/invert into the output register.
// Each stage holds its own valid; a stage advances when the one after it is
// empty or drained, so bubbles close up behind a stalled output.
// arst_n clears stage valids and config registers; payload is not reset.
module multilevel_pixel_quantizer import mpq_pkg::*; #(
	parameter int MAX_THRESHOLDS = 8
) (
	input logic         clk,
	input logic         arst_n,
	mpq_pixel_if.sink   pix,
	mpq_result_if.source res,
	mpq_cfg_if.sink     cfg
);

	localparam logic [REGION_W-1:0] MAX_N = REGION_W'(MAX_THRESHOLDS);

	cfg_t cfg_q;

	logic                cls_valid, cls_ready;
	logic [REGION_W-1:0] cls_region;
	logic [REGION_W-1:0] n;
	logic [PROD_X_W-1:0] num;

	logic                v_s3, v_s4;
	logic                rdy3, rdy4;
	logic [REGION_W-1:0] region_s3, region_s4;
	logic [PROD_W-1:0]   prod_s3;
	logic [GRAY_W-1:0]   gray_s4;
	logic [GRAY_W-1:0]   quot;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_THRESHOLD_COUNT: cfg_q.count    <= cfg.data[REGION_W-1:0];
				REG_THRESHOLDS_LOW:  cfg_q.thr_low  <= cfg.data;
				REG_THRESHOLDS_HIGH: cfg_q.thr_high <= cfg.data;
				REG_INVERT_GRAY:     cfg_q.invert   <= cfg.data[0];
				default: ;
			endcase
		end
	end

	mpq_classify #(
		.MAX_THRESHOLDS(MAX_THRESHOLDS)
	) u_classify (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pix.valid),
		.in_ready (pix.ready),
		.pixel    (pix.pixel),
		.cfg      (cfg_q),
		.out_valid(cls_valid),
		.out_ready(cls_ready),
		.region   (cls_region)
	);

	assign n = clamp_count(cfg_q.count, MAX_N);

	// region*255, plus k-1 for the ceiling in invert mode
	assign num = ({cls_region, 8'd0} - PROD_X_W'(cls_region))
		+ (cfg_q.invert ? PROD_X_W'(n) : '0);

	assign quot = prod_s3[RECIP_SHIFT +: GRAY_W];

	assign rdy4      = !v_s4 || res.ready;
	assign rdy3      = !v_s3 || rdy4;
	assign cls_ready = rdy3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy3) v_s3 <= cls_valid;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && cls_valid) begin
			region_s3 <= cls_region;
			prod_s3   <= PROD_W'(num) * PROD_W'(recip(n));
		end
		if (rdy4 && v_s3) begin
			region_s4 <= region_s3;
			gray_s4   <= cfg_q.invert ? (GRAY_MAX - quot) : quot;
		end
	end

	assign res.valid        = v_s4;
	assign res.region_index = region_s4;
	assign res.gray_level   = gray_s4;

endmodule

>>> rtl/mpq_checker.sv
module mpq_checker import mpq_pkg::*; #(
	parameter int MAX_THRESHOLDS = 8
) (
	input logic                clk,
	input logic                arst_n,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [REGION_W-1:0] region_index,
	input logic [GRAY_W-1:0]   gray_level
);

	localparam logic [REGION_W-1:0] MAX_N = REGION_W'(MAX_THRESHOLDS);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(region_index) && $stable(gray_level))
		else $error("result changed while stalled");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	a_region_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> region_index <= MAX_N)
		else $error("region index out of range");

	a_region0_gray: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && region_index == '0 |-> gray_level == '0 || gray_level == GRAY_MAX)
		else $error("region zero gray level wrong");

endmodule

bind multilevel_pixel_quantizer mpq_checker #(
	.MAX_THRESHOLDS(MAX_THRESHOLDS)
) u_mpq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (pix.ready),
	.out_valid   (res.valid),
	.out_ready   (res.ready),
	.region_index(res.region_index),
	.gray_level  (res.gray_level)
);
